FILE: hw/rtl/trie_pkg.sv
// Shared types and constants for the dictionary trie block.
// Used by the interfaces, the controller, the datapath and the top level.
// No dependencies.
`default_nettype none

package trie_pkg;

  // Pool and alphabet sizes.
  localparam int NODE_COUNT    = 1024;
  localparam int ALPHABET_SIZE = 26;

  // Derived widths and depths.
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int USED_W     = $clog2(NODE_COUNT + 1);
  localparam int LINK_DEPTH = NODE_COUNT * ALPHABET_SIZE;
  localparam int LINK_AW    = $clog2(LINK_DEPTH);

  // Fixed payload widths.
  localparam int SYM_W = 5;
  localparam int POS_W = 32;
  localparam int LEN_W = 16;
  localparam int STS_W = 3;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  typedef enum logic [STS_W-1:0] {
    ST_INSERTED   = 3'd0,
    ST_POOL_FULL  = 3'd1,
    ST_NOT_PREFIX = 3'd2,
    ST_IS_PREFIX  = 3'd3,
    ST_WORD_FOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    FAIL_NONE   = 2'd0,
    FAIL_INSERT = 2'd1,
    FAIL_QUERY  = 2'd2
  } fail_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_NODE,
    S_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic accept;
    logic lookup;
    logic node_access;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/trie_if.sv
// Handshake channels of the dictionary trie: the letter input and the result output.
// Depends on trie_pkg for the payload widths.
`default_nettype none

interface trie_letter_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [trie_pkg::SYM_W-1:0]  symbol;
  logic                        last;
  logic [trie_pkg::POS_W-1:0]  position;
  logic [trie_pkg::LEN_W-1:0]  word_length;

  modport source (output valid, op, symbol, last, position, word_length, input ready);
  modport sink   (input valid, op, symbol, last, position, word_length, output ready);
endinterface

interface trie_result_if;
  logic                        valid;
  logic                        ready;
  logic [trie_pkg::STS_W-1:0]  status;
  logic [trie_pkg::POS_W-1:0]  found_position;
  logic [trie_pkg::LEN_W-1:0]  found_length;

  modport source (output valid, status, found_position, found_length, input ready);
  modport sink   (input valid, status, found_position, found_length, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/trie_ctrl.sv
// Sequencing state machine of the dictionary trie.
// Depends on trie_pkg for the state, command and status types.
`default_nettype none

module trie_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            letter_valid,
  output logic                 letter_ready,
  input  wire trie_pkg::stat_t stat,
  output trie_pkg::cmd_t       cmd
);

  trie_pkg::state_t state;
  trie_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= trie_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      trie_pkg::S_CLEAR: begin
        if (stat.clear_last) state_next = trie_pkg::S_IDLE;
      end
      trie_pkg::S_IDLE: begin
        if (letter_valid) state_next = trie_pkg::S_LOOKUP;
      end
      trie_pkg::S_LOOKUP: begin
        state_next = stat.last ? trie_pkg::S_NODE : trie_pkg::S_IDLE;
      end
      trie_pkg::S_NODE: begin
        state_next = trie_pkg::S_RESULT;
      end
      trie_pkg::S_RESULT: begin
        if (stat.out_free) state_next = trie_pkg::S_IDLE;
      end
      default: state_next = trie_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd          = '0;
    letter_ready = 1'b0;
    unique case (state)
      trie_pkg::S_CLEAR:  cmd.clear = 1'b1;
      trie_pkg::S_IDLE: begin
        letter_ready = 1'b1;
        cmd.accept   = letter_valid;
      end
      trie_pkg::S_LOOKUP: cmd.lookup = 1'b1;
      trie_pkg::S_NODE:   cmd.node_access = 1'b1;
      trie_pkg::S_RESULT: cmd.emit = stat.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/trie_dp.sv
// Datapath of the dictionary trie: link and node memories, walk state and result register.
// Depends on trie_pkg; driven by commands from trie_ctrl.
`default_nettype none

module trie_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire trie_pkg::cmd_t                cmd,
  output trie_pkg::stat_t                    stat,
  input  wire logic                          op,
  input  wire logic [trie_pkg::SYM_W-1:0]    symbol,
  input  wire logic                          last,
  input  wire logic [trie_pkg::POS_W-1:0]    position,
  input  wire logic [trie_pkg::LEN_W-1:0]    word_length,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [trie_pkg::STS_W-1:0]         status,
  output logic [trie_pkg::POS_W-1:0]         found_position,
  output logic [trie_pkg::LEN_W-1:0]         found_length
);

  // Memories.
  logic [trie_pkg::NODE_W-1:0] link_mem [trie_pkg::LINK_DEPTH];
  logic [trie_pkg::POS_W-1:0]  pos_mem  [trie_pkg::NODE_COUNT];
  logic [trie_pkg::LEN_W-1:0]  len_mem  [trie_pkg::NODE_COUNT];

  // Latched letter.
  logic                         op_r;
  logic [trie_pkg::SYM_W-1:0]   sym_r;
  logic                         last_r;
  logic [trie_pkg::POS_W-1:0]   pos_r;
  logic [trie_pkg::LEN_W-1:0]   len_r;
  logic [trie_pkg::LINK_AW-1:0] slot_r;

  // Walk state.
  logic [trie_pkg::NODE_W-1:0]  cursor;
  logic [trie_pkg::NODE_W-1:0]  cursor_next;
  logic [trie_pkg::USED_W-1:0]  nodes_used;
  logic [trie_pkg::USED_W-1:0]  nodes_used_next;
  trie_pkg::fail_t              word_failed;
  trie_pkg::fail_t              word_failed_next;
  logic [trie_pkg::LINK_AW-1:0] clear_cnt;

  // Read data.
  logic [trie_pkg::NODE_W-1:0]  link_rd;
  logic [trie_pkg::POS_W-1:0]   pos_rd;
  logic [trie_pkg::LEN_W-1:0]   len_rd;

  // Result register.
  trie_pkg::status_t            out_status;
  logic [trie_pkg::POS_W-1:0]   out_pos;
  logic [trie_pkg::LEN_W-1:0]   out_len;

  logic [trie_pkg::LINK_AW-1:0] slot;
  logic                         in_sym_ok;
  logic                         sym_ok;
  logic                         link_we;
  logic [trie_pkg::LINK_AW-1:0] link_waddr;
  logic [trie_pkg::NODE_W-1:0]  link_wdata;
  logic                         node_we;
  logic [trie_pkg::NODE_W-1:0]  node_waddr;
  logic [trie_pkg::POS_W-1:0]   node_wpos;
  logic [trie_pkg::LEN_W-1:0]   node_wlen;
  logic                         pool_full;
  logic                         alloc;
  trie_pkg::status_t            res_status;
  logic                         res_found;

  assign slot = trie_pkg::LINK_AW'(cursor) * trie_pkg::LINK_AW'(trie_pkg::ALPHABET_SIZE)
              + trie_pkg::LINK_AW'(symbol);
  assign in_sym_ok = (int'(symbol) < trie_pkg::ALPHABET_SIZE);
  assign sym_ok    = (int'(sym_r) < trie_pkg::ALPHABET_SIZE);
  assign pool_full = (nodes_used >= trie_pkg::USED_W'(trie_pkg::NODE_COUNT));

  // One letter step of the walk.
  always_comb begin
    cursor_next      = cursor;
    nodes_used_next  = nodes_used;
    word_failed_next = word_failed;
    alloc            = 1'b0;
    if (word_failed == trie_pkg::FAIL_NONE) begin
      if (!sym_ok) begin
        word_failed_next = (op_r == trie_pkg::OP_QUERY) ? trie_pkg::FAIL_QUERY
                                                        : trie_pkg::FAIL_INSERT;
      end else if (link_rd == '0) begin
        if (op_r == trie_pkg::OP_QUERY) begin
          word_failed_next = trie_pkg::FAIL_QUERY;
        end else if (pool_full) begin
          word_failed_next = trie_pkg::FAIL_INSERT;
        end else begin
          alloc           = 1'b1;
          cursor_next     = nodes_used[trie_pkg::NODE_W-1:0];
          nodes_used_next = nodes_used + 1'b1;
        end
      end else begin
        cursor_next = link_rd;
      end
    end
  end

  // Write ports: the clearing pass after reset, then link allocation and word storage.
  always_comb begin
    link_we    = cmd.clear || (cmd.lookup && alloc);
    link_waddr = cmd.clear ? clear_cnt : slot_r;
    link_wdata = cmd.clear ? '0 : nodes_used[trie_pkg::NODE_W-1:0];
    node_we    = (cmd.clear && (clear_cnt < trie_pkg::LINK_AW'(trie_pkg::NODE_COUNT)))
              || (cmd.node_access && op_r == trie_pkg::OP_INSERT
                  && word_failed == trie_pkg::FAIL_NONE);
    node_waddr = cmd.clear ? clear_cnt[trie_pkg::NODE_W-1:0] : cursor;
    node_wpos  = cmd.clear ? '0 : pos_r;
    node_wlen  = cmd.clear ? '0 : len_r;
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    if (cmd.accept && in_sym_ok) link_rd <= link_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      pos_mem[node_waddr] <= node_wpos;
      len_mem[node_waddr] <= node_wlen;
    end
    if (cmd.node_access) begin
      pos_rd <= pos_mem[cursor];
      len_rd <= len_mem[cursor];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= op;
      sym_r  <= symbol;
      last_r <= last;
      pos_r  <= position;
      len_r  <= word_length;
      slot_r <= slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor      <= '0;
      nodes_used  <= trie_pkg::USED_W'(1);
      word_failed <= trie_pkg::FAIL_NONE;
      clear_cnt   <= '0;
    end else begin
      if (cmd.clear) clear_cnt <= clear_cnt + 1'b1;
      if (cmd.lookup) begin
        cursor      <= cursor_next;
        nodes_used  <= nodes_used_next;
        word_failed <= word_failed_next;
      end else if (cmd.emit) begin
        cursor      <= '0;
        word_failed <= trie_pkg::FAIL_NONE;
      end
    end
  end

  // Result of a finished word.
  always_comb begin
    res_found = 1'b0;
    if (op_r == trie_pkg::OP_INSERT) begin
      res_status = (word_failed != trie_pkg::FAIL_NONE) ? trie_pkg::ST_POOL_FULL
                                                         : trie_pkg::ST_INSERTED;
    end else if (word_failed != trie_pkg::FAIL_NONE) begin
      res_status = trie_pkg::ST_NOT_PREFIX;
    end else if (len_rd != '0) begin
      res_status = trie_pkg::ST_WORD_FOUND;
      res_found  = 1'b1;
    end else begin
      res_status = trie_pkg::ST_IS_PREFIX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= res_status;
      out_pos    <= res_found ? pos_rd : '0;
      out_len    <= res_found ? len_rd : '0;
    end
  end

  assign status         = out_status;
  assign found_position = out_pos;
  assign found_length   = out_len;

  assign stat.clear_last = (clear_cnt == trie_pkg::LINK_AW'(trie_pkg::LINK_DEPTH - 1));
  assign stat.last       = last_r;
  assign stat.out_free   = !out_valid || out_ready;

  // The pool count stays within the pool and never drops below the root.
  a_used_range: assert property (@(posedge clk) disable iff (rst)
    nodes_used != '0 && nodes_used <= trie_pkg::USED_W'(trie_pkg::NODE_COUNT))
    else $error("nodes_used out of range");

  // The cursor always points at an allocated node.
  a_cursor_alloc: assert property (@(posedge clk) disable iff (rst)
    trie_pkg::USED_W'(cursor) < nodes_used)
    else $error("cursor points past the allocated nodes");

  // Emitting a result loads the output register and rewinds the walk.
  a_emit_rewind: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid && cursor == '0 && word_failed == trie_pkg::FAIL_NONE)
    else $error("result emit did not rewind the walk");

  // Position and length are zero unless the word was found.
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != trie_pkg::ST_WORD_FOUND |-> out_pos == '0 && out_len == '0)
    else $error("nonzero fields on a result other than word_found");

endmodule

`default_nettype wire

FILE: hw/rtl/trie_insert_and_prefix_query.sv
// Top level of the dictionary trie: joins the controller and the datapath to the channels.
// Depends on trie_pkg, trie_if (trie_letter_if, trie_result_if), trie_ctrl and trie_dp.
//
// This block keeps a dictionary trie over the letters a to z in a pool of 1024 nodes,
// each with 26 child links and a stored position and length. Words arrive one letter per
// item on the letter channel, with op selecting insert or query and last marking the final
// letter; exactly one result item comes out per word, at its last letter. After reset the
// block first clears its link and node memories, one link entry per cycle; no letter is
// accepted during that pass. For a letter that is not the last of its word, the accept
// cycle starts the read of the child link of the current node, and the next cycle follows
// or allocates the link. The rate is set by that registered read of the link memory,
// because each letter needs the node the previous one reached. A last letter adds a read
// or write of the node memory and the load of the result register, which waits while an
// earlier result has not yet been taken. A full pool, a symbol beyond z or a missing link
// on a query fails the word: the rest of its letters are skipped and the result is
// pool_full for an insert and not_prefix for a query.
`default_nettype none

module trie_insert_and_prefix_query (
  input  wire logic       clk,
  input  wire logic       rst,
  trie_letter_if.sink     letter,
  trie_result_if.source   result
);

  trie_pkg::cmd_t  cmd;
  trie_pkg::stat_t stat;

  trie_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .letter_valid (letter.valid),
    .letter_ready (letter.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  trie_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .op             (letter.op),
    .symbol         (letter.symbol),
    .last           (letter.last),
    .position       (letter.position),
    .word_length    (letter.word_length),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .status         (result.status),
    .found_position (result.found_position),
    .found_length   (result.found_length)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for trie_insert_and_prefix_query: it drives words, mirrors the trie
// and compares every result item against the mirror's expectation.
// Depends on trie_pkg, trie_if and the RTL of the block; reads nothing else.

module tb;
  import trie_pkg::*;

  // Letters to push through the block (skipped letters of failed words are not counted, but the last letter is).
  localparam int ITEM_TARGET = 1650;
  // Quiet cycles tolerated before the run is declared hung. No item moves during the clearing
  // pass after reset, so the limit sits well above the length of that pass.
  localparam int WATCHDOG_LIMIT = 100000;
  // Cycles to keep watching the result channel once nothing is expected any more.
  localparam int SETTLE_CYCLES = 24;
  localparam int MAX_LETTERS = 32;
  // A symbol code beyond z with every bit set.
  localparam logic [SYM_W-1:0] SYM_BEYOND = 5'd31;

  typedef enum {
    W_FRESH,
    W_REINSERT,
    W_QUERY_HIT,
    W_QUERY_PREFIX,
    W_QUERY_LONGER,
    W_QUERY_RANDOM,
    W_NOISE
  } word_kind_t;

  // A word as a letter string; len counts the letters in use.
  typedef struct packed {
    logic [5:0]                        len;
    logic [MAX_LETTERS-1:0][SYM_W-1:0] letters;
  } word_t;

  typedef struct {
    status_t           status;
    logic [POS_W-1:0]  pos;
    logic [LEN_W-1:0]  len;
  } lookup_outcome_t;

  // Mirror of the trie. Every accepted letter of a word that has not failed walks the mirrored
  // links; a last letter turns into the outcome that the block has to report for that word.
  class dictionary_mirror;
    logic [NODE_W-1:0] links [LINK_DEPTH];
    logic [POS_W-1:0]  stored_pos [NODE_COUNT];
    logic [LEN_W-1:0]  stored_len [NODE_COUNT];
    int unsigned       at_node;
    int unsigned       nodes_used;
    fail_t             failed;
    lookup_outcome_t   awaited [$];
    int                errors;
    int                results_seen;
    int                status_hits [5];
    int unsigned       letters_walked;

    function new();
      foreach (links[i]) links[i] = '0;
      foreach (stored_pos[i]) begin
        stored_pos[i] = '0;
        stored_len[i] = '0;
      end
      foreach (status_hits[i]) status_hits[i] = 0;
      at_node = 0;
      nodes_used = 1;
      failed = FAIL_NONE;
      errors = 0;
      results_seen = 0;
      letters_walked = 0;
    endfunction

    function void note_letter(op_t op, logic [SYM_W-1:0] sym, logic last,
                              logic [POS_W-1:0] pos, logic [LEN_W-1:0] len);
      int unsigned slot;
      int unsigned child;
      lookup_outcome_t outcome;
      if (failed == FAIL_NONE) begin
        letters_walked++;
        if (sym >= ALPHABET_SIZE) begin
          failed = (op == OP_INSERT) ? FAIL_INSERT : FAIL_QUERY;
        end else begin
          slot = at_node * ALPHABET_SIZE + sym;
          child = 32'(links[slot]);
          if (child == 0) begin
            if (op == OP_QUERY) begin
              failed = FAIL_QUERY;
            end else if (nodes_used >= NODE_COUNT) begin
              failed = FAIL_INSERT;
            end else begin
              child = nodes_used;
              nodes_used++;
              links[slot] = child[NODE_W-1:0];
            end
          end
          if (failed == FAIL_NONE) at_node = child;
        end
      end else if (last) begin
        letters_walked++;
      end
      if (!last) return;
      outcome.pos = '0;
      outcome.len = '0;
      if (op == OP_INSERT) begin
        if (failed != FAIL_NONE) begin
          outcome.status = ST_POOL_FULL;
        end else begin
          stored_pos[at_node] = pos;
          stored_len[at_node] = len;
          outcome.status = ST_INSERTED;
        end
      end else if (failed != FAIL_NONE) begin
        outcome.status = ST_NOT_PREFIX;
      end else if (stored_len[at_node] != 0) begin
        outcome.status = ST_WORD_FOUND;
        outcome.pos = stored_pos[at_node];
        outcome.len = stored_len[at_node];
      end else begin
        outcome.status = ST_IS_PREFIX;
      end
      awaited.push_back(outcome);
      at_node = 0;
      failed = FAIL_NONE;
    endfunction

    function void check_result(logic [STS_W-1:0] status, logic [POS_W-1:0] pos,
                               logic [LEN_W-1:0] len);
      lookup_outcome_t want;
      if (awaited.size() == 0) begin
        $error("result item with no word pending: status %0d, found_position %0h, %s %0d",
               status, pos, "found_length", len);
        errors++;
        return;
      end
      want = awaited.pop_front();
      results_seen++;
      status_hits[int'(want.status)]++;
      if (status !== want.status) begin
        $error("status: expected %0d (%s), actual %0d", want.status, want.status.name(), status);
        errors++;
      end
      if (pos !== want.pos) begin
        $error("found_position: expected %0h, actual %0h", want.pos, pos);
        errors++;
      end
      if (len !== want.len) begin
        $error("found_length: expected %0d, actual %0d", want.len, len);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   send_idle;
  int   recv_stall;
  dictionary_mirror board;

  trie_letter_if letter ();
  trie_result_if result ();

  trie_insert_and_prefix_query dut (
    .clk    (clk),
    .rst    (rst),
    .letter (letter),
    .result (result)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // The result side: ready is redrawn at every falling edge, so a stall can land on any
  // cycle of the block's work, including the cycle its result register is loaded.
  always @(negedge clk) begin
    result.ready <= ($urandom_range(99) >= recv_stall);
  end

  // Both channels are observed at the rising edge. The result is checked before the letter
  // is noted; a letter can never cause a result in its own accept cycle, so the order of
  // the two only matters for readability.
  always @(posedge clk) begin
    if (!rst) begin
      if (result.valid && result.ready)
        board.check_result(result.status, result.found_position, result.found_length);
      if (letter.valid && letter.ready)
        board.note_letter(op_t'(letter.op), letter.symbol, letter.last, letter.position,
                          letter.word_length);
    end
  end

  // Ends the run if neither channel moves an item for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((letter.valid && letter.ready) || (result.valid && result.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no item moved for %0d cycles.", WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // Offers one letter from a falling edge and holds it until the block takes it. The
  // sender may idle first, redrawing at each falling edge; valid stays high between back-to-back items.
  task automatic send_letter(input op_t op, input logic [SYM_W-1:0] sym, input logic last,
                             input logic [POS_W-1:0] pos, input logic [LEN_W-1:0] len);
    while ($urandom_range(99) < send_idle) begin
      letter.valid = 1'b0;
      @(negedge clk);
    end
    letter.valid       = 1'b1;
    letter.op          = op;
    letter.symbol      = sym;
    letter.last        = last;
    letter.position    = pos;
    letter.word_length = len;
    @(posedge clk);
    while (!letter.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Sends a whole word with one op. Only the last letter's position and length matter to
  // the block, so the earlier letters carry random values there.
  task automatic send_word(input op_t op, input word_t w, input logic [POS_W-1:0] pos,
                           input logic [LEN_W-1:0] len);
    for (int i = 0; i < w.len; i++) begin
      if (i == w.len - 1)
        send_letter(op, w.letters[i], 1'b1, pos, len);
      else
        send_letter(op, w.letters[i], 1'b0, $urandom(), LEN_W'($urandom_range(65535)));
    end
  endtask

  initial begin : stimulus
    word_t      known [$];
    word_t      w;
    word_kind_t kind;
    int         roll;
    int         phase;
    int         extra;
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] len;

    // Every input is known from time zero; reset is held, then released at a falling edge.
    rst                = 1'b1;
    letter.valid       = 1'b0;
    letter.op          = OP_INSERT;
    letter.symbol      = '0;
    letter.last        = 1'b0;
    letter.position    = '0;
    letter.word_length = '0;
    result.ready       = 1'b1;
    send_idle          = 0;
    recv_stall         = 0;
    board = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed words, with no idling on either side.
    // Single letter a with all-ones position and length, then found again.
    send_letter(OP_INSERT, 5'd0, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
    send_letter(OP_QUERY, 5'd0, 1'b1, 32'h0, 16'h0);
    // zz inserted with a zero length: the node exists but ends no word.
    send_letter(OP_INSERT, 5'd25, 1'b0, 32'h0, 16'h0);
    send_letter(OP_INSERT, 5'd25, 1'b1, 32'h0, 16'h0);
    send_letter(OP_QUERY, 5'd25, 1'b0, 32'h0, 16'h0);
    send_letter(OP_QUERY, 5'd25, 1'b1, 32'h0, 16'h0);
    // A letter that was never inserted.
    send_letter(OP_QUERY, 5'd16, 1'b1, 32'h0, 16'h0);
    // A symbol beyond z fails an insert; the following letter is skipped.
    send_letter(OP_INSERT, SYM_BEYOND, 1'b0, 32'hA5A5_5A5A, 16'h1234);
    send_letter(OP_INSERT, 5'd3, 1'b1, 32'h5A5A_A5A5, 16'h4321);
    // A symbol beyond z on the last letter of a query.
    send_letter(OP_QUERY, 5'd0, 1'b0, 32'h0, 16'h0);
    send_letter(OP_QUERY, 5'd26, 1'b1, 32'h0, 16'h0);
    // A query that misses early; the letters after the miss must not be walked.
    send_letter(OP_QUERY, 5'd5, 1'b0, 32'h0, 16'h0);
    send_letter(OP_QUERY, 5'd0, 1'b0, 32'h0, 16'h0);
    send_letter(OP_QUERY, 5'd0, 1'b1, 32'h0, 16'h0);
    // Mixed ops: an insert letter makes b, then a query letter misses below it.
    send_letter(OP_INSERT, 5'd1, 1'b0, 32'h0, 16'h0);
    send_letter(OP_QUERY, 5'd2, 1'b1, 32'h0, 16'h0);
    // Mixed ops: a query letter walks to a, an insert last letter stores ab.
    send_letter(OP_QUERY, 5'd0, 1'b0, 32'h0, 16'h0);
    send_letter(OP_INSERT, 5'd1, 1'b1, 32'h1234_5678, 16'h0001);
    send_letter(OP_QUERY, 5'd0, 1'b0, 32'h0, 16'h0);
    send_letter(OP_QUERY, 5'd1, 1'b1, 32'h0, 16'h0);
    // A query miss earlier in the word turns an insert last letter into pool_full.
    send_letter(OP_QUERY, 5'd23, 1'b0, 32'h0, 16'h0);
    send_letter(OP_INSERT, 5'd23, 1'b1, 32'hDEAD_BEEF, 16'h00FF);
    // Overwriting a stored word replaces both position and length.
    send_letter(OP_INSERT, 5'd0, 1'b1, 32'h0000_0005, 16'h0007);
    send_letter(OP_QUERY, 5'd0, 1'b1, 32'h0, 16'h0);

    // Random words. While the pool still has room, most words are long fresh inserts, so
    // the pool runs out partway through and the rest of the run sees pool_full as well as
    // queries against a full dictionary. The four idle patterns take a quarter each.
    while (board.letters_walked < ITEM_TARGET) begin
      phase = board.letters_walked * 4 / ITEM_TARGET;
      case (phase)
        0: begin
          send_idle = 0;
          recv_stall = 0;
        end
        1: begin
          send_idle = 47;
          recv_stall = 0;
        end
        2: begin
          send_idle = 0;
          recv_stall = 47;
        end
        default: begin
          send_idle = 22;
          recv_stall = 22;
        end
      endcase

      roll = $urandom_range(99);
      if (known.size() == 0 || (board.nodes_used < NODE_COUNT && roll < 65))
        kind = W_FRESH;
      else begin
        roll = $urandom_range(99);
        if (roll < 20)      kind = W_FRESH;
        else if (roll < 30) kind = W_REINSERT;
        else if (roll < 55) kind = W_QUERY_HIT;
        else if (roll < 70) kind = W_QUERY_PREFIX;
        else if (roll < 78) kind = W_QUERY_LONGER;
        else if (roll < 85) kind = W_QUERY_RANDOM;
        else                kind = W_NOISE;
      end

      pos = $urandom();
      case ($urandom_range(9))
        0:       len = '0;
        1:       len = 16'hFFFF;
        default: len = LEN_W'($urandom_range(65535));
      endcase

      w = '0;
      if (kind != W_FRESH && kind != W_QUERY_RANDOM && kind != W_NOISE)
        w = known[$urandom_range(known.size() - 1)];

      case (kind)
        W_FRESH: begin
          w.len = (board.nodes_used < NODE_COUNT) ? 6'($urandom_range(24, 8))
                                                  : 6'($urandom_range(8, 1));
          for (int i = 0; i < w.len; i++)
            w.letters[i] = SYM_W'($urandom_range(ALPHABET_SIZE - 1));
          known.push_back(w);
          send_word(OP_INSERT, w, pos, len);
        end
        W_REINSERT: send_word(OP_INSERT, w, pos, len);
        W_QUERY_HIT: send_word(OP_QUERY, w, pos, len);
        W_QUERY_PREFIX: begin
          if (w.len > 1) w.len = 6'($urandom_range(w.len - 1, 1));
          send_word(OP_QUERY, w, pos, len);
        end
        W_QUERY_LONGER: begin
          extra = $urandom_range(3, 1);
          for (int i = 0; i < extra; i++)
            w.letters[w.len + i] = SYM_W'($urandom_range(ALPHABET_SIZE - 1));
          w.len = 6'(w.len + extra);
          send_word(OP_QUERY, w, pos, len);
        end
        W_QUERY_RANDOM: begin
          w.len = 6'($urandom_range(6, 1));
          for (int i = 0; i < w.len; i++)
            w.letters[i] = SYM_W'($urandom_range(ALPHABET_SIZE - 1));
          send_word(OP_QUERY, w, pos, len);
        end
        default: begin
          // Noise: each letter draws its own op, and symbols may fall beyond z.
          extra = $urandom_range(4, 1);
          for (int i = 0; i < extra; i++)
            send_letter(op_t'($urandom_range(1)), SYM_W'($urandom_range(31)), i == extra - 1,
                        $urandom(), LEN_W'($urandom_range(65535)));
        end
      endcase
    end

    // Drain: wait for every expected result, then watch a while longer for strays.
    letter.valid = 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d words over %0d walked letters in four idle patterns;",
             board.results_seen, board.letters_walked);
    $display("%0d of %0d nodes in use. Results seen: %0d inserted, %0d pool_full,",
             board.nodes_used, NODE_COUNT, board.status_hits[ST_INSERTED],
             board.status_hits[ST_POOL_FULL]);
    $display("%0d not_prefix, %0d is_prefix, %0d word_found.",
             board.status_hits[ST_NOT_PREFIX], board.status_hits[ST_IS_PREFIX],
             board.status_hits[ST_WORD_FOUND]);
    if (board.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
